### rtl/fpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_W    = DATA_W - 1;
  localparam int SPAN_W    = DATA_W + 1;
  localparam int DIV_W     = 23;
  localparam int QUOT_W    = FRAC_W + 1;
  localparam int SIDE_W    = 4;
  localparam int CFG_IDX_W = 4;
  localparam int WGT_W     = 5;
  localparam int DEN_W     = DATA_W + 2;

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERR_NB  = 4'd0,
    CFG_ERR_NS  = 4'd1,
    CFG_ERR_PS  = 4'd2,
    CFG_ERR_PB  = 4'd3,
    CFG_DERR_NB = 4'd4,
    CFG_DERR_NS = 4'd5,
    CFG_DERR_PS = 4'd6,
    CFG_DERR_PB = 4'd7
  } cfg_idx_t;

  localparam logic signed [DATA_W-1:0] RST_NB = -(DATA_W'(1) << (FRAC_W - 3));
  localparam logic signed [DATA_W-1:0] RST_NS = -(DATA_W'(1) << (FRAC_W - 4));
  localparam logic [FRAC_W-1:0]        RST_PS = FRAC_W'(1) << (FRAC_W - 4);
  localparam logic [FRAC_W-1:0]        RST_PB = FRAC_W'(1) << (FRAC_W - 3);

endpackage

`default_nettype wire

### rtl/fuzzy_pd_controller_5x5.sv
`timescale 1ns / 1ps
`default_nettype none

// Fuzzy PD controller, 5x5 rules, triangular memberships. Takes one
// (error, error change) pair per cycle unless the output stalls, and returns
// one duty cycle per pair via a 16-stage divider per input for the membership
// degrees, three stages for degrees, rule strengths and weighted sums, and a
// second 16-stage divider for the weighted average. Backpressure on the output
// stalls the whole pipeline. Write breakpoints via cfg only when idle; not enforced.
module fuzzy_pd_controller_5x5 (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [31:0]                   s_tdata,   // error_value, error_change
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [15:0]                        m_tdata,   // duty_cycle
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import fpd_pkg::*;

  typedef struct packed {
    logic              sat;
    logic [2:0]        idx;
    logic [SPAN_W-1:0] numr;
    logic [SPAN_W-1:0] span;
  } seg_t;

  logic signed [DATA_W-1:0] e_nb, e_ns, d_nb, d_ns;
  logic [FRAC_W-1:0]        e_ps, e_pb, d_ps, d_pb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_nb <= RST_NB; e_ns <= RST_NS; e_ps <= RST_PS; e_pb <= RST_PB;
      d_nb <= RST_NB; d_ns <= RST_NS; d_ps <= RST_PS; d_pb <= RST_PB;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ERR_NB:  e_nb <= cfg_data;
        CFG_ERR_NS:  e_ns <= cfg_data;
        CFG_ERR_PS:  e_ps <= cfg_data[FRAC_W-1:0];
        CFG_ERR_PB:  e_pb <= cfg_data[FRAC_W-1:0];
        CFG_DERR_NB: d_nb <= cfg_data;
        CFG_DERR_NS: d_ns <= cfg_data;
        CFG_DERR_PS: d_ps <= cfg_data[FRAC_W-1:0];
        CFG_DERR_PB: d_pb <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic seg_t locate(logic signed [DATA_W-1:0] x,
                                  logic signed [DATA_W-1:0] p0,
                                  logic signed [DATA_W-1:0] p1,
                                  logic [FRAC_W-1:0] p3,
                                  logic [FRAC_W-1:0] p4);
    logic signed [DATA_W+1:0] xs, b0, b1, b3, b4;
    seg_t s;
    xs = {{2{x[DATA_W-1]}}, x};
    b0 = {{2{p0[DATA_W-1]}}, p0};
    b1 = {{2{p1[DATA_W-1]}}, p1};
    b3 = {3'b000, p3};
    b4 = {3'b000, p4};
    s = '0;
    if (xs <= b0) begin
      s.sat = 1'b1;
      s.idx = 3'd0;
    end else if (xs <= b1) begin
      s.idx = 3'd0; s.numr = SPAN_W'(xs - b0); s.span = SPAN_W'(b1 - b0);
    end else if (xs <= 0) begin
      s.idx = 3'd1; s.numr = SPAN_W'(xs - b1); s.span = SPAN_W'(-b1);
    end else if (xs <= b3) begin
      s.idx = 3'd2; s.numr = SPAN_W'(xs); s.span = SPAN_W'(b3);
    end else if (xs <= b4) begin
      s.idx = 3'd3; s.numr = SPAN_W'(xs - b3); s.span = SPAN_W'(b4 - b3);
    end else begin
      s.sat = 1'b1;
      s.idx = 3'd4;
    end
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] min16(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage A: segment search
  seg_t sa_e, sa_d;
  logic va;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_e <= locate(s_tdata[15:0], e_nb, e_ns, e_ps, e_pb);
      sa_d <= locate(s_tdata[31:16], d_nb, d_ns, d_ps, d_pb);
    end
  end

  // membership dividers
  logic              ve, vd_unused;
  logic [QUOT_W-1:0] qe, qd;
  logic              rne, rnd;
  logic [SIDE_W-1:0] se, sdd;

  fpd_div u_div_e (
    .clk, .rst, .en,
    .in_valid (va),
    .num      (DIV_W'(sa_e.numr)),
    .den      (DIV_W'(sa_e.span)),
    .side     ({sa_e.sat, sa_e.idx}),
    .out_valid(ve),
    .quot     (qe),
    .rem_nz   (rne),
    .out_side (se)
  );

  fpd_div u_div_d (
    .clk, .rst, .en,
    .in_valid (va),
    .num      (DIV_W'(sa_d.numr)),
    .den      (DIV_W'(sa_d.span)),
    .side     ({sa_d.sat, sa_d.idx}),
    .out_valid(vd_unused),
    .quot     (qd),
    .rem_nz   (rnd),
    .out_side (sdd)
  );

  // stage B: degrees
  logic              vb;
  logic [DATA_W-1:0] el, eh, dl, dh;
  logic [2:0]        ea, da;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= ve && vd_unused;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea <= se[2:0];
      da <= sdd[2:0];
      eh <= se[3]  ? '0  : qe;
      el <= se[3]  ? ONE : ONE - qe - DATA_W'(rne);
      dh <= sdd[3] ? '0  : qd;
      dl <= sdd[3] ? ONE : ONE - qd - DATA_W'(rnd);
    end
  end

  // stage C: rule strengths
  logic              vc;
  logic [DATA_W-1:0] s00, s01, s10, s11;
  logic [WGT_W-1:0]  wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s00 <= min16(el, dl);
      s01 <= min16(el, dh);
      s10 <= min16(eh, dl);
      s11 <= min16(eh, dh);
      wb  <= {ea[2:0], 2'b00} + WGT_W'(ea) + WGT_W'(da) + WGT_W'(1);
    end
  end

  // stage D: weighted sums
  logic             vdd, zr;
  logic [DIV_W-1:0] num, den25;
  logic [DEN_W-1:0] den;

  assign den = DEN_W'(s00) + DEN_W'(s01) + DEN_W'(s10) + DEN_W'(s11);

  always_ff @(posedge clk) begin
    if (rst) begin
      vdd <= 1'b0;
    end else if (en) begin
      vdd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num   <= DIV_W'(s00) * DIV_W'(wb) + DIV_W'(s01) * DIV_W'(WGT_W'(wb + 5'd1))
             + DIV_W'(s10) * DIV_W'(WGT_W'(wb + 5'd5))
             + DIV_W'(s11) * DIV_W'(WGT_W'(wb + 5'd6));
      den25 <= DIV_W'(den) * DIV_W'(25);
      zr    <= (den == '0);
    end
  end

  // average divider
  logic              vf, rnf;
  logic [QUOT_W-1:0] qf;
  logic [SIDE_W-1:0] sf;

  fpd_div u_div_avg (
    .clk, .rst, .en,
    .in_valid (vdd),
    .num      (num),
    .den      (den25),
    .side     ({3'b000, zr}),
    .out_valid(vf),
    .quot     (qf),
    .rem_nz   (rnf),
    .out_side (sf)
  );

  // output register
  logic rnf_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= sf[0] ? '0 : qf;
      rnf_q   <= rnf;
    end
  end

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= ONE && !(m_tdata == ONE && rnf_q)))
    else $error("duty cycle above one");

  a_degree_sum: assert property (@(posedge clk) disable iff (rst)
    vb |-> ((DATA_W+1)'(el) + (DATA_W+1)'(eh) == (DATA_W+1)'(ONE)
         || (DATA_W+1)'(el) + (DATA_W+1)'(eh) == (DATA_W+1)'(ONE) - 1'b1))
    else $error("error degrees do not sum to one");

  a_div_align: assert property (@(posedge clk) disable iff (rst)
    ve == vd_unused)
    else $error("membership dividers out of step");

endmodule

`default_nettype wire

### rtl/fpd_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage; expects num <= den
module fpd_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [fpd_pkg::DIV_W-1:0]  num,
  input  wire logic [fpd_pkg::DIV_W-1:0]  den,
  input  wire logic [fpd_pkg::SIDE_W-1:0] side,
  output logic                            out_valid,
  output logic [fpd_pkg::QUOT_W-1:0]      quot,
  output logic                            rem_nz,
  output logic [fpd_pkg::SIDE_W-1:0]      out_side
);
  import fpd_pkg::*;

  logic [QUOT_W-1:0] vld;
  logic [DIV_W-1:0]  rem  [QUOT_W];
  logic [DIV_W-1:0]  dv   [QUOT_W];
  logic [QUOT_W-1:0] qv   [QUOT_W];
  logic [SIDE_W-1:0] sd   [QUOT_W];

  function automatic logic [DIV_W:0] trial(logic [DIV_W:0] t, logic [DIV_W-1:0] d);
    logic [DIV_W:0] dx;
    dx = {1'b0, d};
    if (t >= dx) begin
      return {1'b1, DIV_W'(t - dx)};
    end
    return {1'b0, t[DIV_W-1:0]};
  endfunction

  logic [DIV_W:0] st [QUOT_W];

  always_comb begin
    st[0] = trial({1'b0, num}, den);
    for (int i = 1; i < QUOT_W; i++) begin
      st[i] = trial({rem[i-1], 1'b0}, dv[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUOT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= st[0][DIV_W-1:0];
      qv[0]  <= QUOT_W'(st[0][DIV_W]);
      dv[0]  <= den;
      sd[0]  <= side;
      for (int i = 1; i < QUOT_W; i++) begin
        rem[i] <= st[i][DIV_W-1:0];
        qv[i]  <= {qv[i-1][QUOT_W-2:0], st[i][DIV_W]};
        dv[i]  <= dv[i-1];
        sd[i]  <= sd[i-1];
      end
    end
  end

  assign out_valid = vld[QUOT_W-1];
  assign quot      = qv[QUOT_W-1];
  assign rem_nz    = |rem[QUOT_W-1];
  assign out_side  = sd[QUOT_W-1];

endmodule

`default_nettype wire

### test/fpd_checker.sv
`timescale 1ns / 1ps

module fpd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [31:0]                   s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [15:0]                   m_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            duties_seen
);
  import fpd_pkg::*;

  typedef longint pts_t [5];

  logic [15:0] bp_reg [8];
  logic [15:0] duty_q [$];

  function automatic pts_t grades(longint x, pts_t p);
    pts_t g;
    longint span;
    for (int s = 0; s < 5; s++) g[s] = 0;
    if (x <= p[0]) begin
      g[0] = 32768;
      return g;
    end
    for (int s = 0; s < 4; s++) begin
      if (x > p[s] && x <= p[s+1]) begin
        span = p[s+1] - p[s];
        g[s] = ((p[s+1] - x) * 32768) / span;
        g[s+1] = ((x - p[s]) * 32768) / span;
        return g;
      end
    end
    g[4] = 32768;
    return g;
  endfunction

  function automatic pts_t points(int base);
    pts_t p;
    p[0] = longint'($signed(bp_reg[base]));
    p[1] = longint'($signed(bp_reg[base+1]));
    p[2] = 0;
    p[3] = longint'(bp_reg[base+2][14:0]);
    p[4] = longint'(bp_reg[base+3][14:0]);
    return p;
  endfunction

  function automatic logic [15:0] duty_of(logic [15:0] e, logic [15:0] de);
    pts_t ge, gd;
    longint num, den, s;
    logic [63:0] q;
    ge = grades(longint'($signed(e)), points(CFG_ERR_NB));
    gd = grades(longint'($signed(de)), points(CFG_DERR_NB));
    num = 0;
    den = 0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        s = ge[i] < gd[j] ? ge[i] : gd[j];
        num += s * (5 * i + j + 1);
        den += s;
      end
    end
    if (den == 0) return 16'd0;
    q = (num <<< 15) / (den * 25);
    return q[15:0];
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    duties_seen = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      bp_reg[CFG_ERR_NB]  <= RST_NB;
      bp_reg[CFG_ERR_NS]  <= RST_NS;
      bp_reg[CFG_ERR_PS]  <= {1'b0, RST_PS};
      bp_reg[CFG_ERR_PB]  <= {1'b0, RST_PB};
      bp_reg[CFG_DERR_NB] <= RST_NB;
      bp_reg[CFG_DERR_NS] <= RST_NS;
      bp_reg[CFG_DERR_PS] <= {1'b0, RST_PS};
      bp_reg[CFG_DERR_PB] <= {1'b0, RST_PB};
      duty_q.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= CFG_DERR_PB) begin
        if (cfg_index[1]) bp_reg[cfg_index] <= {1'b0, cfg_data[14:0]};
        else bp_reg[cfg_index] <= cfg_data;
      end
      if (s_tvalid && s_tready) duty_q.push_back(duty_of(s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        duties_seen++;
        if (duty_q.size() == 0) report("unexpected duty_cycle", m_tdata, 16'd0);
        else begin
          if (m_tdata !== duty_q[0]) report("duty_cycle", m_tdata, duty_q[0]);
          void'(duty_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) pending <= duty_q.size();

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fpd_pkg::*;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 s_tvalid = 0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // error_value, error_change
  logic                 m_tvalid;
  logic                 m_tready = 0;
  logic [15:0]          m_tdata;        // duty_cycle
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ERR_NB;
  logic [15:0]          cfg_data = '0;

  int  fail_count, pending, duties_seen;
  int  cycles = 0;
  int  items_sent = 0;
  int  cfg_writes = 0;
  bit  idle_on = 1;
  bit  hold = 0;

  always #2 clk = ~clk;

  fuzzy_pd_controller_5x5 i_dut (.*);

  fpd_checker i_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 300000) begin
      $display("timeout after %0d cycles", cycles);
      $display("** fuzzy_pd_controller_5x5: FAILED **");
      $finish;
    end
  end

  always @(posedge clk)
    m_tready <= hold ? 1'b0 : (idle_on ? ($urandom_range(99) >= 19) : 1'b1);

  task automatic send(logic [15:0] e, logic [15:0] de);
    while (idle_on && $urandom_range(99) < 19) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {de, e};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [15:0] rand_bp(int idx, int mode);
    if (idx % 4 < 2) begin
      if (mode == 0) return 16'h8000;
      if (mode == 1) return 16'h0000;
      return 16'(-$urandom_range(0, 32768));
    end
    if (mode == 0) return 16'h7fff;
    if (mode == 1) return 16'h0000;
    return {1'($urandom), 15'($urandom_range(0, 32767))};
  endfunction

  task automatic setup(int mode);
    for (int i = CFG_ERR_NB; i <= CFG_DERR_PB; i++)
      write_reg(CFG_IDX_W'(i), rand_bp(i, mode));
  endtask

  function automatic logic [15:0] rand_in();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 16383)) - 8192);
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                        : 16'h8000 + 16'($urandom_range(3));
    endcase
  endfunction

  task automatic random_run(int n);
    for (int k = 0; k < n; k++) send(rand_in(), rand_in());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(16'h0000, 16'h0000);
    send(16'h8000, 16'h8000);
    send(16'h7fff, 16'h7fff);
    send(16'h8000, 16'h7fff);
    send(16'h7fff, 16'h8000);
    send(16'hf000, 16'hf000);
    send(16'hf800, 16'h0800);
    send(16'h1000, 16'hf001);
    send(16'hf400, 16'h0c00);
    send(16'h0400, 16'hfc00);
    send(16'h0001, 16'hffff);
    send(16'h1001, 16'hefff);
    send(16'h5555, 16'haaaa);
    drain();

    // all breakpoints at zero: inputs fall to NB or PB only
    setup(1);
    send(16'h0000, 16'h0000);
    send(16'h0001, 16'hffff);
    send(16'h8000, 16'h7fff);
    drain();
    setup(0);
    send(16'h0000, 16'h0000);
    send(16'h8001, 16'h7ffe);
    send(16'hc000, 16'h4000);
    drain();
    // disordered: NS below NB, PB below PS
    write_reg(CFG_ERR_NS, 16'h8000);
    write_reg(CFG_ERR_NB, 16'hc000);
    write_reg(CFG_ERR_PS, 16'h6000);
    write_reg(CFG_ERR_PB, 16'h1000);
    write_reg(CFG_DERR_PB, 16'hffff);
    write_reg(CFG_IDX_W'(int'(CFG_DERR_PB) + 1), 16'h1234);
    write_reg('1, 16'h0000);
    send(16'hb000, 16'h0800);
    send(16'h0800, 16'h8000);
    send(16'h3000, 16'h7fff);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      setup(2);
      if (ph == 2) idle_on = 0;
      if (ph == 4) begin
        fork
          begin
            hold = 1;
            repeat (400) @(posedge clk);
            hold = 0;
          end
          random_run(125);
        join
      end else random_run(125);
      drain();
      idle_on = 1;
    end

    $display("%0d items sent, %0d duty cycles checked, %0d breakpoint writes",
             items_sent, duties_seen, cfg_writes);
    $display("covered: extremes, zero and disordered breakpoints, long output stall");
    if (fail_count == 0) begin
      $display("** fuzzy_pd_controller_5x5: PASSED **");
    end else begin
      $display("** fuzzy_pd_controller_5x5: FAILED **");
    end
    $finish;
  end

endmodule
